[sv/partition_fit_allocator_unit_defines.svh]
// Assertion macros shared by the allocator RTL.
`ifndef PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define PFA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define PFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pfa_pkg.sv]
package pfa_pkg;

  // Index width of the scan packet; covers up to 256 holes
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 5;
  localparam int FIT_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Allocation policies
  localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 1'd1;

  // Input item functions
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  hole_index;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_index;
    logic [15:0] hole_size_before;
  } out_item_t;

  // Control part of the search packet that walks the cell row
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } pkt_ctl_t;

  // Broadcast write to one cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } upd_t;

endpackage

[sv/pfa_cell.sv]
module pfa_cell #(
  parameter int CELL_IDX   = 0,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pfa_pkg::FIT_W-1:0]   mode,
  input  logic [pfa_pkg::CNT_W-1:0]   count,
  input  pfa_pkg::upd_t               upd,
  input  logic [SIZE_WIDTH-1:0]       upd_data,
  input  pfa_pkg::pkt_ctl_t           in_ctl,
  input  logic [SIZE_WIDTH-1:0]       in_req,
  input  logic [SIZE_WIDTH-1:0]       in_size,
  output pfa_pkg::pkt_ctl_t           out_ctl,
  output logic [SIZE_WIDTH-1:0]       out_req,
  output logic [SIZE_WIDTH-1:0]       out_size
);
  import pfa_pkg::*;

  logic [SIZE_WIDTH-1:0] hole;
  logic                  active;
  logic                  fits;
  logic                  take;

  assign active = (32'(count) > 32'(CELL_IDX));
  assign fits   = (hole >= in_req);

  // Does this hole replace the packet's current pick
  always_comb begin
    case (mode)
      FIT_FIRST: take = active && fits && !in_ctl.found;
      FIT_BEST:  take = active && fits && (!in_ctl.found || hole < in_size);
      FIT_WORST: take = active && (!in_ctl.found || hole > in_size);
      default:   take = 1'b0;
    endcase
  end

  // Hole storage, written by load or by the post-grant subtract
  always_ff @(posedge clk) begin
    if (upd.en && upd.idx == IDX_W'(CELL_IDX)) begin
      hole <= upd_data;
    end
  end

  // Packet handoff to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_req <= in_req;
    if (take) begin
      out_ctl.found <= 1'b1;
      out_ctl.idx   <= IDX_W'(CELL_IDX);
      out_size      <= hole;
    end else begin
      out_ctl.found <= in_ctl.found;
      out_ctl.idx   <= in_ctl.idx;
      out_size      <= in_size;
    end
  end

endmodule

[sv/partition_fit_allocator_unit.sv]
// Hole table allocator. A load item writes one hole size; its result (all
// zero) passes through the pending register to the output register. An
// allocate item sends a search packet down a row of MAX_HOLES cells, one cell
// per cycle, each cell holding one hole, and its result takes the same path.
// The input stalls during a scan and while a result is pending, so no new item
// is taken before the last result reaches the output register; a new item is
// taken while a finished result still waits there. Hole entries are not
// cleared by reset and must be loaded before an allocate scans them.
`include "partition_fit_allocator_unit_defines.svh"

module partition_fit_allocator_unit #(
  parameter int MAX_HOLES  = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pfa_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pfa_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pfa_pkg::*;

  logic [FIT_W-1:0]      fit_mode;
  logic [CNT_W-1:0]      hole_count;
  logic                  scanning;
  logic                  pend_valid;
  out_item_t             pend;
  logic                  in_xfer;
  logic                  out_free;
  logic [SIZE_WIDTH-1:0] amt;
  logic                  grant;

  pkt_ctl_t              pkt_ctl  [0:MAX_HOLES];
  logic [SIZE_WIDTH-1:0] pkt_req  [0:MAX_HOLES];
  logic [SIZE_WIDTH-1:0] pkt_size [0:MAX_HOLES];
  logic [MAX_HOLES:0]    pkt_vld;

  upd_t                  upd;
  logic [SIZE_WIDTH-1:0] upd_data;

  assign in_stall = scanning || pend_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign amt      = SIZE_WIDTH'(in_data.amount);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= FIT_FIRST;
      hole_count <= CNT_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_MODE:   fit_mode   <= cfg_data[FIT_W-1:0];
        CFG_HOLE_COUNT: hole_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Packet launch at the head of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_ctl[0].valid <= 1'b0;
    end else begin
      pkt_ctl[0].valid <= in_xfer && in_data.func == FUNC_ALLOC;
    end
  end

  always_ff @(posedge clk) begin
    pkt_ctl[0].found <= 1'b0;
    pkt_ctl[0].idx   <= '0;
    pkt_req[0]       <= amt;
    pkt_size[0]      <= '0;
  end

  // Cell row
  for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
    pfa_cell #(
      .CELL_IDX   (i),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .mode     (fit_mode),
      .count    (hole_count),
      .upd      (upd),
      .upd_data (upd_data),
      .in_ctl   (pkt_ctl[i]),
      .in_req   (pkt_req[i]),
      .in_size  (pkt_size[i]),
      .out_ctl  (pkt_ctl[i+1]),
      .out_req  (pkt_req[i+1]),
      .out_size (pkt_size[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_HOLES; i++) begin : g_vld
    assign pkt_vld[i] = pkt_ctl[i].valid;
  end

  // Worst fit picks the largest hole first, then checks it fits
  assign grant = pkt_ctl[MAX_HOLES].found &&
                 (fit_mode != FIT_WORST || pkt_size[MAX_HOLES] >= pkt_req[MAX_HOLES]);

  // Hole writes: a load, or the subtract after a grant
  always_comb begin
    if (pkt_ctl[MAX_HOLES].valid) begin
      upd.en   = grant;
      upd.idx  = pkt_ctl[MAX_HOLES].idx;
      upd_data = pkt_size[MAX_HOLES] - pkt_req[MAX_HOLES];
    end else begin
      upd.en   = in_xfer && in_data.func == FUNC_LOAD;
      upd.idx  = IDX_W'(in_data.hole_index);
      upd_data = amt;
    end
  end

  // Scan busy flag and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (in_xfer && in_data.func == FUNC_ALLOC) begin
        scanning <= 1'b1;
      end else if (pkt_ctl[MAX_HOLES].valid) begin
        scanning <= 1'b0;
      end
      if (pkt_ctl[MAX_HOLES].valid || (in_xfer && in_data.func == FUNC_LOAD)) begin
        pend_valid <= 1'b1;
      end else if (out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_ctl[MAX_HOLES].valid) begin
      pend.granted          <= grant;
      pend.chosen_index     <= grant ? 4'(pkt_ctl[MAX_HOLES].idx) : 4'd0;
      pend.hole_size_before <= grant ? 16'(pkt_size[MAX_HOLES]) : 16'd0;
    end else if (in_xfer) begin
      pend <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      out_data <= pend;
    end
  end

  // Checks
  `PFA_ASSERT_ALWAYS(a_one_packet, $onehot0(pkt_vld), "more than one search packet in flight")
  `PFA_ASSERT_IMPL(a_end_while_scan, pkt_ctl[MAX_HOLES].valid,
                   scanning && !pend_valid, "packet ended outside a scan")
  `PFA_ASSERT_ALWAYS(a_busy_excl, !(scanning && pend_valid), "scan and pending result overlap")
  `PFA_ASSERT_NEXT(a_alloc_scan, in_xfer && in_data.func == FUNC_ALLOC,
                   scanning, "allocate did not start a scan")
  `PFA_ASSERT_IMPL(a_nogrant_zero, out_valid && !out_data.granted,
                   out_data.chosen_index == 4'd0 && out_data.hole_size_before == 16'd0,
                   "no-grant result not zero")

endmodule
